@@ src/cplx_pkg.sv @@
// ----------------------------------------------------------------------------
// cplx_pkg
// Shared widths, operation and status codes, pipeline structs and the
// saturation helper of the complex fixed-point ALU.
// ----------------------------------------------------------------------------
package cplx_pkg;

	localparam int W     = 16;        // operand and result part width
	localparam int F     = 8;         // fraction bits
	localparam int PW    = 2 * W;     // product width
	localparam int SW    = 2 * W + 2; // sum width with headroom
	localparam int DQW   = PW + F;    // scaled dividend / quotient width
	localparam int NCELL = DQW;       // one divider cell per quotient bit

	typedef enum logic [2:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_DIV = 3'd3,
		MODE_EQ  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef struct packed {
		logic         sat;
		logic [W-1:0] val;
	} sat_t;

	// Beat travelling down the divider chain.
	typedef struct packed {
		logic           vld;
		logic           is_div;
		logic           divz;
		logic           equal;
		logic           pre_sat;
		logic [W-1:0]   pre_re;
		logic [W-1:0]   pre_im;
		logic           neg_re;
		logic           neg_im;
		logic [PW-1:0]  den;
		logic [PW-1:0]  rem_re;
		logic [PW-1:0]  rem_im;
		logic [DQW-1:0] dq_re;
		logic [DQW-1:0] dq_im;
	} chain_t;

	// Clamp a wide signed value to W bits.
	function automatic sat_t sat_pack(input logic signed [SW-1:0] v);
		sat_t                  r;
		logic signed [SW-1:0]  pmax;
		logic signed [SW-1:0]  nmin;
		pmax  = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
		nmin  = -pmax - SW'(1);
		r.sat = 1'b0;
		r.val = v[W-1:0];
		if (v > pmax) begin
			r.sat = 1'b1;
			r.val = pmax[W-1:0];
		end else if (v < nmin) begin
			r.sat = 1'b1;
			r.val = nmin[W-1:0];
		end
		return r;
	endfunction

endpackage

@@ src/cplx_intf.sv @@
// ----------------------------------------------------------------------------
// cplx channel interfaces
// Operand and result channels of the complex fixed-point ALU.
// ----------------------------------------------------------------------------
interface cplx_opnd_if import cplx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [2:0]          mode;
	logic signed [W-1:0] a_re;
	logic signed [W-1:0] a_im;
	logic signed [W-1:0] b_re;
	logic signed [W-1:0] b_im;

	modport source(output valid, mode, a_re, a_im, b_re, b_im, input ready);
	modport sink(input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cplx_res_if import cplx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] res_re;
	logic signed [W-1:0] res_im;
	logic                equal;
	logic [1:0]          status;

	modport source(output valid, res_re, res_im, equal, status, input ready);
	modport sink(input valid, res_re, res_im, equal, status, output ready);
endinterface

@@ src/cplx_front.sv @@
// ----------------------------------------------------------------------------
// cplx_front
// Two stages: products and squares, then sums, saturation of the direct
// modes and setup of the divider chain.
// ----------------------------------------------------------------------------
module cplx_front import cplx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  logic [2:0]          mode,
	input  logic signed [W-1:0] a_re,
	input  logic signed [W-1:0] a_im,
	input  logic signed [W-1:0] b_re,
	input  logic signed [W-1:0] b_im,
	output chain_t              head
);

	typedef struct packed {
		logic          vld;
		logic [2:0]    mode;
		logic [W-1:0]  ar;
		logic [W-1:0]  ai;
		logic [W-1:0]  br;
		logic [W-1:0]  bi;
		logic [PW-1:0] p_rr;
		logic [PW-1:0] p_ii;
		logic [PW-1:0] p_ri;
		logic [PW-1:0] p_ir;
		logic [PW-1:0] sq_r;
		logic [PW-1:0] sq_i;
	} s1_t;

	s1_t    s1_d, stage_s1;
	chain_t s2_d, stage_s2;

	always_comb begin
		logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir, m_br, m_bi;
		m_rr = a_re * b_re;
		m_ii = a_im * b_im;
		m_ri = a_re * b_im;
		m_ir = a_im * b_re;
		m_br = b_re * b_re;
		m_bi = b_im * b_im;
		s1_d.vld  = vld;
		s1_d.mode = mode;
		s1_d.ar   = a_re;
		s1_d.ai   = a_im;
		s1_d.br   = b_re;
		s1_d.bi   = b_im;
		s1_d.p_rr = m_rr;
		s1_d.p_ii = m_ii;
		s1_d.p_ri = m_ri;
		s1_d.p_ir = m_ir;
		s1_d.sq_r = m_br;
		s1_d.sq_i = m_bi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (en) begin
			stage_s1 <= s1_d;
		end
	end

	always_comb begin
		logic signed [SW-1:0] v_re, v_im, n_re, n_im, m_re, m_im;
		sat_t                 x_re, x_im;
		v_re = '0;
		v_im = '0;
		case (stage_s1.mode)
			MODE_ADD: begin
				v_re = $signed(stage_s1.ar) + $signed(stage_s1.br);
				v_im = $signed(stage_s1.ai) + $signed(stage_s1.bi);
			end
			MODE_SUB: begin
				v_re = $signed(stage_s1.ar) - $signed(stage_s1.br);
				v_im = $signed(stage_s1.ai) - $signed(stage_s1.bi);
			end
			MODE_MUL: begin
				v_re = ($signed(stage_s1.p_rr) - $signed(stage_s1.p_ii)) >>> F;
				v_im = ($signed(stage_s1.p_ri) + $signed(stage_s1.p_ir)) >>> F;
			end
			default: begin
				v_re = '0;
				v_im = '0;
			end
		endcase
		x_re = sat_pack(v_re);
		x_im = sat_pack(v_im);

		n_re = $signed(stage_s1.p_rr) + $signed(stage_s1.p_ii);
		n_im = $signed(stage_s1.p_ir) - $signed(stage_s1.p_ri);
		m_re = n_re[SW-1] ? -n_re : n_re;
		m_im = n_im[SW-1] ? -n_im : n_im;

		s2_d.vld     = stage_s1.vld;
		s2_d.den     = stage_s1.sq_r + stage_s1.sq_i;
		s2_d.divz    = (stage_s1.mode == MODE_DIV) && (s2_d.den == '0);
		s2_d.is_div  = (stage_s1.mode == MODE_DIV) && !s2_d.divz;
		s2_d.equal   = (stage_s1.ar == stage_s1.br) && (stage_s1.ai == stage_s1.bi);
		s2_d.pre_re  = x_re.val;
		s2_d.pre_im  = x_im.val;
		s2_d.pre_sat = x_re.sat | x_im.sat;
		s2_d.neg_re  = n_re[SW-1];
		s2_d.neg_im  = n_im[SW-1];
		s2_d.rem_re  = '0;
		s2_d.rem_im  = '0;
		s2_d.dq_re   = {m_re[PW-1:0], {F{1'b0}}};
		s2_d.dq_im   = {m_im[PW-1:0], {F{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else if (en) begin
			stage_s2 <= s2_d;
		end
	end

	assign head = stage_s2;

endmodule

@@ src/cplx_div_cell.sv @@
// ----------------------------------------------------------------------------
// cplx_div_cell
// One restoring-division step for both lanes: shift in the next dividend
// bit, compare against the divisor, subtract and emit one quotient bit.
// ----------------------------------------------------------------------------
module cplx_div_cell import cplx_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  chain_t d,
	output chain_t q
);

	chain_t        nxt;
	logic [PW:0]   r2_re, r2_im, df_re, df_im;
	logic          ge_re, ge_im;

	always_comb begin
		r2_re = {d.rem_re, d.dq_re[DQW-1]};
		r2_im = {d.rem_im, d.dq_im[DQW-1]};
		df_re = r2_re - {1'b0, d.den};
		df_im = r2_im - {1'b0, d.den};
		ge_re = r2_re >= {1'b0, d.den};
		ge_im = r2_im >= {1'b0, d.den};
		nxt        = d;
		nxt.rem_re = ge_re ? df_re[PW-1:0] : r2_re[PW-1:0];
		nxt.rem_im = ge_im ? df_im[PW-1:0] : r2_im[PW-1:0];
		nxt.dq_re  = {d.dq_re[DQW-2:0], ge_re};
		nxt.dq_im  = {d.dq_im[DQW-2:0], ge_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

@@ src/complex_fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Complex add, subtract, multiply, divide and equality on signed Q8.8 parts.
//
//   channel  dir  payload                       handshake
//   opnd     in   mode, a_re, a_im, b_re, b_im  valid/ready
//   res      out  res_re, res_im, equal, status valid/ready
//
// One beat per cycle sustained unless the output stalls; the pipeline holds
// two front stages, one divider cell per quotient bit and an output register.
// The divider chain does one restoring step per cell.
// Reset clears all valid flags; no beat is in flight after reset.
// A stalled output holds the whole pipeline; opnd.ready drops with it.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu import cplx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cplx_opnd_if.sink   opnd,
	cplx_res_if.source  res
);

	chain_t              chain [0:NCELL];
	logic                adv;
	logic                out_vld_q;
	logic [W-1:0]        out_re_q, out_im_q;
	logic                out_eq_q;
	logic [1:0]          out_st_q;
	sat_t                f_re, f_im;
	logic [1:0]          f_st;

	assign adv        = !out_vld_q || res.ready;
	assign opnd.ready = adv;

	cplx_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld    (opnd.valid),
		.mode   (opnd.mode),
		.a_re   (opnd.a_re),
		.a_im   (opnd.a_im),
		.b_re   (opnd.b_re),
		.b_im   (opnd.b_im),
		.head   (chain[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		cplx_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	function automatic sat_t quo_pack(input logic neg, input logic [DQW-1:0] qv);
		sat_t           r;
		logic [DQW-1:0] pmax;
		logic [DQW-1:0] nmag;
		pmax  = DQW'((64'd1 << (W - 1)) - 64'd1);
		nmag  = DQW'(64'd1 << (W - 1));
		r.sat = 1'b0;
		if (!neg) begin
			if (qv > pmax) begin
				r.sat = 1'b1;
				r.val = pmax[W-1:0];
			end else begin
				r.val = qv[W-1:0];
			end
		end else begin
			if (qv > nmag) begin
				r.sat = 1'b1;
				r.val = nmag[W-1:0];
			end else begin
				r.val = -qv[W-1:0];
			end
		end
		return r;
	endfunction

	always_comb begin
		sat_t q_re, q_im;
		q_re = quo_pack(chain[NCELL].neg_re, chain[NCELL].dq_re);
		q_im = quo_pack(chain[NCELL].neg_im, chain[NCELL].dq_im);
		if (chain[NCELL].is_div) begin
			f_re = q_re;
			f_im = q_im;
		end else begin
			f_re.sat = chain[NCELL].pre_sat;
			f_re.val = chain[NCELL].pre_re;
			f_im.sat = 1'b0;
			f_im.val = chain[NCELL].pre_im;
		end
		if (chain[NCELL].divz) begin
			f_st = ST_DIVZ;
		end else if (f_re.sat || f_im.sat) begin
			f_st = ST_SAT;
		end else begin
			f_st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= chain[NCELL].vld;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			out_re_q <= f_re.val;
			out_im_q <= f_im.val;
			out_eq_q <= chain[NCELL].equal;
			out_st_q <= f_st;
		end
	end

	assign res.valid  = out_vld_q;
	assign res.res_re = out_re_q;
	assign res.res_im = out_im_q;
	assign res.equal  = out_eq_q;
	assign res.status = out_st_q;

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == ST_DIVZ |-> res.res_re == '0 && res.res_im == '0)
		else $error("divide by zero with nonzero parts");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.status == ST_OK || res.status == ST_SAT || res.status == ST_DIVZ)
		else $error("undefined status code");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !opnd.ready)
		else $error("operand accepted while result stalled");

endmodule
